// ===== hw/rtl/keyed_table_swap_remove_defines.svh =====
// Assertion macros shared by the keyed table checker.
`ifndef KEYED_TABLE_SWAP_REMOVE_DEFINES_SVH
`define KEYED_TABLE_SWAP_REMOVE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyed table check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define KTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyed table check failed");

`endif

// ===== hw/rtl/kts_pkg.sv =====
// Shared constants and codes for the keyed table with swap remove.
package kts_pkg;

	// Table geometry
	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Fixed port widths
	localparam int ACT_W   = 2;
	localparam int KEY_W   = 32;
	localparam int COST_W  = 32;
	localparam int TYPE_W  = 8;
	localparam int STAT_W  = 2;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 5;
	localparam int CAP_W   = 5;
	localparam int PAY_W   = COST_W + TYPE_W;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_FIND   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_DUP     = 2'd2,
		STAT_MISSING = 2'd3
	} status_t;

endpackage

// ===== hw/rtl/kts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/keyed_table_swap_remove.sv =====
// Keyed table of unique entries: add, swap remove and find by key.
//
// Usage: drive action, item_id, item_cost and item_type with start high;
// the transaction is taken at a clock edge where start is high and busy low.
// Each transaction yields one result: status, slot_index and entry_count
// shown for exactly one cycle with done high. The receiver cannot stall.
// capacity is written through cfg_wr_en / cfg_wr_data while idle.
// Steps, start edge to done:
//   add refused as full, unused action: result registered at the start edge
//   otherwise: a key scan (one key read per cycle from the key RAM, compare
//   on the registered read data), stopping early on a hit, then the result;
//   an append adds the S_APPEND state, a remove with move of the last entry
//   adds S_MOVE_RD and S_MOVE_WR.
// busy falls with done, so a new transaction may start in the cycle
// its predecessor's result is shown.
// Reset clears the live count to zero and capacity to 16; the RAM contents
// stay undefined, only slots below the live count are ever read.
module keyed_table_swap_remove
	import kts_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [ACT_W-1:0]   action,
	input  logic [KEY_W-1:0]   item_id,
	input  logic [COST_W-1:0]  item_cost,
	input  logic [TYPE_W-1:0]  item_type,
	input  logic               cfg_wr_en,
	input  logic [CAP_W-1:0]   cfg_wr_data,
	output logic               done,
	output logic [STAT_W-1:0]  status,
	output logic [SLOT_W-1:0]  slot_index,
	output logic [COUNT_W-1:0] entry_count
);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_SCAN    = 5'b00010,
		S_APPEND  = 5'b00100,
		S_MOVE_RD = 5'b01000,
		S_MOVE_WR = 5'b10000
	} state_t;

	state_t              state_q;
	action_t             act_q;
	logic [KEY_W-1:0]    key_q;
	logic [PAY_W-1:0]    pay_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CAP_W-1:0]    cap_q;
	logic [CNT_W-1:0]    idx_q;
	logic [IDX_W-1:0]    pos_q;
	logic                pend_s1;
	logic [IDX_W-1:0]    addr_s1;
	logic                done_q;
	status_t             status_q;
	logic [IDX_W-1:0]    slot_q;
	logic [CNT_W-1:0]    count_out_q;

	logic [CNT_W-1:0]    limit;
	logic [CNT_W-1:0]    cnt_dec;
	logic [IDX_W-1:0]    last_idx;
	logic                issue;
	logic                hit;
	logic                scan_end;
	logic [KEY_W-1:0]    key_rdata;
	logic [PAY_W-1:0]    pay_rdata;
	logic                key_we;
	logic                key_re;
	logic [IDX_W-1:0]    waddr;
	logic [IDX_W-1:0]    key_raddr;
	logic [KEY_W-1:0]    key_wdata;
	logic [PAY_W-1:0]    pay_wdata;

	// Effective capacity saturates at the table depth
	assign limit    = (32'(cap_q) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(cap_q);
	assign cnt_dec  = cnt_q - 1'b1;
	assign last_idx = cnt_dec[IDX_W-1:0];

	// Scan pipeline: read key at idx_q, compare in the cycle after the read
	assign issue    = (state_q == S_SCAN) && (idx_q < cnt_q);
	assign hit      = pend_s1 && (key_rdata == key_q);
	assign scan_end = (state_q == S_SCAN) && (hit || (!issue && !pend_s1));

	// RAM port steering
	assign key_re    = issue || (state_q == S_MOVE_RD);
	assign key_raddr = (state_q == S_MOVE_RD) ? last_idx : idx_q[IDX_W-1:0];
	assign key_we    = (state_q == S_APPEND) || (state_q == S_MOVE_WR);
	assign waddr     = (state_q == S_APPEND) ? cnt_q[IDX_W-1:0] : pos_q;
	assign key_wdata = (state_q == S_APPEND) ? key_q : key_rdata;
	assign pay_wdata = (state_q == S_APPEND) ? pay_q : pay_rdata;

	kts_ram #(
		.WIDTH (KEY_W),
		.DEPTH (DEPTH)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (waddr),
		.wdata (key_wdata),
		.re    (key_re),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	// Cost and type travel together
	kts_ram #(
		.WIDTH (PAY_W),
		.DEPTH (DEPTH)
	) u_pay_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (waddr),
		.wdata (pay_wdata),
		.re    (state_q == S_MOVE_RD),
		.raddr (last_idx),
		.rdata (pay_rdata)
	);

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(16);
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_q       <= ACT_ADD;
			key_q       <= '0;
			pay_q       <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			pend_s1     <= 1'b0;
			addr_s1     <= '0;
			done_q      <= 1'b0;
			status_q    <= STAT_OK;
			slot_q      <= '0;
			count_out_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q <= action_t'(action);
						key_q <= item_id;
						pay_q <= {item_cost, item_type};
						if (action_t'(action) == ACT_ADD && cnt_q >= limit) begin
							done_q      <= 1'b1;
							status_q    <= STAT_FULL;
							slot_q      <= '0;
							count_out_q <= cnt_q;
						end else if (action_t'(action) == ACT_NONE) begin
							done_q      <= 1'b1;
							status_q    <= STAT_MISSING;
							slot_q      <= '0;
							count_out_q <= cnt_q;
						end else begin
							done_q  <= 1'b0;
							idx_q   <= '0;
							pend_s1 <= 1'b0;
							state_q <= S_SCAN;
						end
					end else begin
						done_q <= 1'b0;
					end
				end
				S_SCAN: begin
					pend_s1 <= issue && !scan_end;
					addr_s1 <= idx_q[IDX_W-1:0];
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (scan_end) begin
						if (hit) begin
							pos_q <= addr_s1;
							case (act_q)
								ACT_FIND: begin
									done_q      <= 1'b1;
									status_q    <= STAT_OK;
									slot_q      <= addr_s1;
									count_out_q <= cnt_q;
									state_q     <= S_IDLE;
								end
								ACT_REMOVE: begin
									if (addr_s1 == last_idx) begin
										// Last slot: nothing to move
										cnt_q       <= cnt_dec;
										done_q      <= 1'b1;
										status_q    <= STAT_OK;
										slot_q      <= addr_s1;
										count_out_q <= cnt_dec;
										state_q     <= S_IDLE;
									end else begin
										done_q  <= 1'b0;
										state_q <= S_MOVE_RD;
									end
								end
								default: begin
									done_q      <= 1'b1;
									status_q    <= STAT_DUP;
									slot_q      <= '0;
									count_out_q <= cnt_q;
									state_q     <= S_IDLE;
								end
							endcase
						end else if (act_q == ACT_ADD) begin
							done_q  <= 1'b0;
							state_q <= S_APPEND;
						end else begin
							done_q      <= 1'b1;
							status_q    <= STAT_MISSING;
							slot_q      <= '0;
							count_out_q <= cnt_q;
							state_q     <= S_IDLE;
						end
					end else begin
						done_q <= 1'b0;
					end
				end
				S_APPEND: begin
					cnt_q       <= cnt_q + 1'b1;
					done_q      <= 1'b1;
					status_q    <= STAT_OK;
					slot_q      <= cnt_q[IDX_W-1:0];
					count_out_q <= cnt_q + 1'b1;
					state_q     <= S_IDLE;
				end
				S_MOVE_RD: begin
					done_q  <= 1'b0;
					state_q <= S_MOVE_WR;
				end
				S_MOVE_WR: begin
					cnt_q       <= cnt_dec;
					done_q      <= 1'b1;
					status_q    <= STAT_OK;
					slot_q      <= pos_q;
					count_out_q <= cnt_dec;
					state_q     <= S_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Outputs
	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign slot_index  = SLOT_W'(slot_q);
	assign entry_count = COUNT_W'(count_out_q);

endmodule

// ===== hw/rtl/kts_checker.sv =====
// Port-level checker for the keyed table, bound to the top level.
`include "keyed_table_swap_remove_defines.svh"

module kts_checker
	import kts_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [STAT_W-1:0]  status,
	input logic [SLOT_W-1:0]  slot_index,
	input logic [COUNT_W-1:0] entry_count
);

	// Result cycle never overlaps a running transaction
	`KTS_ASSERT_NOW(a_done_idle, done, !busy)
	// Refused or missing results report slot zero
	`KTS_ASSERT_NOW(a_fail_slot, done && status != STAT_OK, slot_index == '0)
	// Count never exceeds the table depth
	`KTS_ASSERT_NOW(a_count_max, done, 32'(entry_count) <= DEPTH)
	// An accepted transaction either answers at once or keeps busy
	`KTS_ASSERT_NEXT(a_accept_prog, start && !busy, done || busy)

endmodule

bind keyed_table_swap_remove kts_checker u_kts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.slot_index  (slot_index),
	.entry_count (entry_count)
);

// ===== tb/sv/keyed_table_swap_remove_test.sv =====
// Self-checking testbench for the keyed table with swap remove.
`timescale 1ns / 100ps

module keyed_table_swap_remove_test;
	import kts_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int PHASE_ITEMS  = 150;
	localparam int PHASE_COUNT  = 13;
	localparam int POOL_SIZE    = 20;
	localparam int SETTLE_CYCLES = 25;

	// Expected content of one result transaction
	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] count;
	} table_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	action_t            action = ACT_ADD;
	logic [KEY_W-1:0]   item_id = '0;
	logic [COST_W-1:0]  item_cost = '0;
	logic [TYPE_W-1:0]  item_type = '0;
	logic               cfg_wr_en = 1'b0;
	logic [CAP_W-1:0]   cfg_wr_data = '0;
	logic               done;
	logic [STAT_W-1:0]  status;
	logic [SLOT_W-1:0]  slot_index;
	logic [COUNT_W-1:0] entry_count;

	// Shadow table kept in step with accepted transactions
	logic [KEY_W-1:0]   shadow_keys [DEPTH];
	logic [COST_W-1:0]  shadow_costs [DEPTH];
	logic [TYPE_W-1:0]  shadow_types [DEPTH];
	int                 shadow_count = 0;
	int                 shadow_capacity = 16;

	table_result_t      pending_results [$];
	int                 error_count = 0;
	int                 cycle_count = 0;
	logic [KEY_W-1:0]   key_pool [POOL_SIZE];

	keyed_table_swap_remove dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.item_id     (item_id),
		.item_cost   (item_cost),
		.item_type   (item_type),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.done        (done),
		.status      (status),
		.slot_index  (slot_index),
		.entry_count (entry_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("keyed_table_swap_remove_test NOT OK");
			$finish;
		end
	end

	// Applies one operation to the shadow table and returns its result
	function automatic table_result_t apply_table_op(action_t op, logic [KEY_W-1:0] id,
			logic [COST_W-1:0] cost, logic [TYPE_W-1:0] kind);
		table_result_t res;
		int hit;
		int lim;
		int last;
		res.status = STAT_MISSING;
		res.slot = '0;
		lim = (shadow_capacity < DEPTH) ? shadow_capacity : DEPTH;
		hit = -1;
		for (int i = 0; i < shadow_count; i++) begin
			if (hit < 0 && shadow_keys[i] == id)
				hit = i;
		end
		case (op)
			ACT_ADD: begin
				// full wins over duplicate
				if (shadow_count >= lim) begin
					res.status = STAT_FULL;
				end else if (hit >= 0) begin
					res.status = STAT_DUP;
				end else begin
					shadow_keys[shadow_count] = id;
					shadow_costs[shadow_count] = cost;
					shadow_types[shadow_count] = kind;
					res.slot = shadow_count[SLOT_W-1:0];
					res.status = STAT_OK;
					shadow_count++;
				end
			end
			ACT_REMOVE: begin
				// last entry moves into the freed slot
				if (hit >= 0) begin
					last = shadow_count - 1;
					shadow_keys[hit] = shadow_keys[last];
					shadow_costs[hit] = shadow_costs[last];
					shadow_types[hit] = shadow_types[last];
					shadow_count = last;
					res.slot = hit[SLOT_W-1:0];
					res.status = STAT_OK;
				end
			end
			ACT_FIND: begin
				if (hit >= 0) begin
					res.slot = hit[SLOT_W-1:0];
					res.status = STAT_OK;
				end
			end
			default: ;
		endcase
		res.count = shadow_count[COUNT_W-1:0];
		return res;
	endfunction

	// Result checker: each done cycle is compared with the oldest expectation
	always @(posedge clk) begin : check_results
		table_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d slot_index %0d entry_count %0d",
					status, slot_index, entry_count);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					error_count++;
				end
				if (slot_index !== want.slot) begin
					$error("slot_index: expected %0d, got %0d", want.slot, slot_index);
					error_count++;
				end
				if (entry_count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count, entry_count);
					error_count++;
				end
			end
		end
	end

	// Sends one transaction; start stays high so a following one can go back to back
	task automatic send_table_op(action_t op, logic [KEY_W-1:0] id,
			logic [COST_W-1:0] cost, logic [TYPE_W-1:0] kind);
		table_result_t expected;
		start <= 1'b1;
		action <= op;
		item_id <= id;
		item_cost <= cost;
		item_type <= kind;
		do @(posedge clk); while (busy);
		expected = apply_table_op(op, id, cost, kind);
		pending_results = {pending_results, expected};
	endtask

	task automatic send_random_payload(action_t op, logic [KEY_W-1:0] id);
		send_table_op(op, id, $urandom, 8'($urandom_range(0, 255)));
	endtask

	task automatic hold_off(int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Waits until every expected result has arrived
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(int value);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value[CAP_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_capacity = value;
	endtask

	// Mostly short gaps, a few long ones
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	function automatic action_t random_action(int add_pct, int remove_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < add_pct)
			return ACT_ADD;
		if (r < add_pct + remove_pct)
			return ACT_REMOVE;
		if (r < 97)
			return ACT_FIND;
		return ACT_NONE;
	endfunction

	// Lookups and the unused action on an empty table
	task automatic test_empty_table();
		send_table_op(ACT_FIND, 32'h0000_0005, '0, '0);
		send_table_op(ACT_REMOVE, 32'h0000_0000, '0, '0);
		send_table_op(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		drain_results();
	endtask

	// Add, duplicate, find, swap remove and last-slot remove
	task automatic test_add_find_remove();
		send_table_op(ACT_ADD, 32'h0000_0000, 32'h0000_0000, 8'h00);
		send_table_op(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		send_table_op(ACT_ADD, 32'h0000_0000, 32'h1234_5678, 8'h5A);
		send_table_op(ACT_ADD, 32'h1234_5678, 32'h8765_4321, 8'hA5);
		send_table_op(ACT_FIND, 32'hFFFF_FFFF, '0, '0);
		send_table_op(ACT_REMOVE, 32'h0000_0000, '0, '0);
		send_table_op(ACT_FIND, 32'h1234_5678, '0, '0);
		send_table_op(ACT_REMOVE, 32'hFFFF_FFFF, '0, '0);
		send_table_op(ACT_NONE, 32'h1234_5678, '0, '0);
		send_table_op(ACT_REMOVE, 32'h1234_5678, '0, '0);
		drain_results();
	endtask

	// Capacity zero refuses every add as full, even a duplicate
	task automatic test_capacity_zero();
		send_random_payload(ACT_ADD, 32'h00C0_FFEE);
		write_capacity(0);
		send_random_payload(ACT_ADD, 32'h00C0_FFEE);
		send_random_payload(ACT_ADD, 32'h0BAD_F00D);
		drain_results();
	endtask

	// Capacity above the table size saturates at the table size
	task automatic test_capacity_saturation();
		write_capacity(31);
		for (int i = 0; shadow_count < DEPTH; i++)
			send_random_payload(ACT_ADD, 32'h5A5A_0000 + i);
		send_random_payload(ACT_ADD, 32'h7777_7777);
		send_random_payload(ACT_ADD, 32'h5A5A_0000);
		drain_results();
	endtask

	// Capacity lowered under the live count keeps entries, refuses adds
	task automatic test_capacity_shrink();
		write_capacity(4);
		send_random_payload(ACT_ADD, 32'h7777_7777);
		send_random_payload(ACT_REMOVE, 32'h5A5A_0003);
		send_random_payload(ACT_ADD, 32'h7777_7777);
		drain_results();
	endtask

	// Phases of random traffic over a small key pool, each with its own capacity
	task automatic test_random_traffic();
		int cap_plan [PHASE_COUNT] = '{16, 31, 8, 0, 1, 17, 15, 2, 31, 4, 16, 31, 16};
		int add_pct;
		int remove_pct;
		// clear what the directed part left behind
		write_capacity(16);
		while (shadow_count > 0)
			send_random_payload(ACT_REMOVE, shadow_keys[0]);
		for (int p = 0; p < PHASE_COUNT; p++) begin
			for (int k = 0; k < POOL_SIZE; k++)
				key_pool[k] = $urandom;
			if (p % 5 == 2) begin
				key_pool[0] = 32'h0000_0000;
				key_pool[1] = 32'hFFFF_FFFF;
			end
			write_capacity((p == PHASE_COUNT - 1) ? $urandom_range(0, 31) : cap_plan[p]);
			// balanced, fill-heavy and drain-heavy phases
			case (p % 3)
				0: begin add_pct = 40; remove_pct = 25; end
				1: begin add_pct = 60; remove_pct = 15; end
				default: begin add_pct = 20; remove_pct = 45; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_random_payload(random_action(add_pct, remove_pct),
					($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_SIZE - 1)]);
				// every fourth phase runs back to back
				if (p % 4 != 1)
					hold_off(random_gap());
			end
		end
		drain_results();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_add_find_remove();
		test_capacity_zero();
		test_capacity_saturation();
		test_capacity_shrink();
		test_random_traffic();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("keyed_table_swap_remove_test OK");
		else
			$display("keyed_table_swap_remove_test NOT OK");
		$finish;
	end

endmodule

// ===== keyed_table_swap_remove.f =====
+incdir+hw/rtl
hw/rtl/kts_pkg.sv
hw/rtl/kts_ram.sv
hw/rtl/keyed_table_swap_remove.sv
hw/rtl/kts_checker.sv
tb/sv/keyed_table_swap_remove_test.sv
